/* rtl/matmul_b_panel_pack_addr_unit_defines.svh */
// Assertion macros shared by the panel packing address unit.
// Expects clk and arst_n in the scope of each use.
`ifndef MATMUL_B_PANEL_PACK_ADDR_UNIT_DEFINES_SVH
`define MATMUL_B_PANEL_PACK_ADDR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MMBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mmbp_pkg.sv */
// Shared types, constants and the panel size table for the panel packing
// address unit. No dependencies.
`default_nettype none

package mmbp_pkg;

	// Configuration register file
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_MODE = 2'd2;

	// Panel widths, widest first
	localparam int LEVELS  = 6;
	localparam int LEVEL_W = 3;
	localparam int SIZE_W  = 5;

	typedef struct packed {
		logic [CFG_W-1:0] source_rows;
		logic [CFG_W-1:0] source_cols;
		logic             transpose_mode;
	} cfg_t;

	// One step request from the pipeline to the walker
	typedef struct packed {
		logic step;
		logic restart;
	} walk_ctl_t;

	function automatic logic [SIZE_W-1:0] level_width(input logic [LEVEL_W-1:0] level);
		logic [SIZE_W-1:0] sz;
		unique case (level)
			3'd0:    sz = 5'd24;
			3'd1:    sz = 5'd16;
			3'd2:    sz = 5'd8;
			3'd3:    sz = 5'd4;
			3'd4:    sz = 5'd2;
			3'd5:    sz = 5'd1;
			default: sz = 5'd0;
		endcase
		return sz;
	endfunction

endpackage

`default_nettype wire

/* rtl/mmbp_cfg_regs.sv */
// Configuration registers of the panel packing address unit.
// Depends on mmbp_pkg.
`default_nettype none

module mmbp_cfg_regs
	import mmbp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic             trans_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= CFG_W'(1);
			cols_q  <= CFG_W'(1);
			trans_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_ROWS:    rows_q  <= cfg_data;
				REG_SOURCE_COLS:    cols_q  <= cfg_data;
				REG_TRANSPOSE_MODE: trans_q <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	assign cfg.source_rows    = rows_q;
	assign cfg.source_cols    = cols_q;
	assign cfg.transpose_mode = trans_q;

endmodule

`default_nettype wire

/* rtl/mmbp_walk.sv */
// Panel walk state and per-step address arithmetic: computes the result of
// one step and updates the walk state when the step is taken. Depends on mmbp_pkg.
`default_nettype none

module mmbp_walk
	import mmbp_pkg::*;
#(
	parameter int MAX_DIM    = 4096,
	parameter int INDEX_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire walk_ctl_t             ctl,
	output logic [INDEX_BITS-1:0]      source_index,
	output logic [INDEX_BITS-1:0]      dest_index,
	output logic                       last_element,
	output logic                       exhausted
);

	`include "matmul_b_panel_pack_addr_unit_defines.svh"

	localparam int DIM_BITS = $clog2(MAX_DIM + 1);
	localparam int CMP_BITS = (DIM_BITS > CFG_W) ? DIM_BITS : CFG_W;
	localparam int OFF_BITS = ((DIM_BITS > SIZE_W) ? DIM_BITS : SIZE_W) + 1;
	localparam int PROD_W   = 2 * DIM_BITS;
	localparam int SUM_W    = PROD_W + 1;

	// Walk state
	logic [LEVEL_W-1:0]    level_q;
	logic [DIM_BITS-1:0]   offset_q;
	logic [DIM_BITS-1:0]   row_q;
	logic [SIZE_W-1:0]     col_q;
	logic [INDEX_BITS-1:0] dest_q;
	logic                  fin_q;
	logic [DIM_BITS-1:0]   lat_cols_q;
	logic [DIM_BITS-1:0]   lat_h_q;
	logic [DIM_BITS-1:0]   lat_w_q;
	logic                  lat_trans_q;

	// Effective state after an optional restart
	logic [DIM_BITS-1:0]   clamp_r;
	logic [DIM_BITS-1:0]   clamp_c;
	logic [LEVEL_W-1:0]    e_level;
	logic [DIM_BITS-1:0]   e_offset;
	logic [DIM_BITS-1:0]   e_row;
	logic [SIZE_W-1:0]     e_col;
	logic [INDEX_BITS-1:0] e_dest;
	logic                  e_fin;
	logic [DIM_BITS-1:0]   e_cols;
	logic [DIM_BITS-1:0]   e_h;
	logic [DIM_BITS-1:0]   e_w;
	logic                  e_trans;

	// Next state
	logic [LEVEL_W-1:0]    n_level;
	logic [DIM_BITS-1:0]   n_offset;
	logic [DIM_BITS-1:0]   n_row;
	logic [SIZE_W-1:0]     n_col;
	logic [INDEX_BITS-1:0] n_dest;
	logic                  n_fin;

	// Address datapath
	logic [SIZE_W-1:0]     cur_size;
	logic [DIM_BITS-1:0]   lcol;
	logic [DIM_BITS-1:0]   mul_a;
	logic [DIM_BITS-1:0]   mul_c;
	logic [PROD_W-1:0]     prod;
	logic [SUM_W-1:0]      src_sum;
	logic [OFF_BITS-1:0]   off_next;

	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_BITS-1:0] d;
		if (CMP_BITS'(v) > CMP_BITS'(MAX_DIM))
			d = DIM_BITS'(MAX_DIM);
		else
			d = DIM_BITS'(v);
		return d;
	endfunction

	// First panel level at or after start that still fits; LEVELS if none
	function automatic logic [LEVEL_W-1:0] settle(input logic [LEVEL_W-1:0]  start,
						      input logic [OFF_BITS-1:0] off,
						      input logic [DIM_BITS-1:0] w);
		logic [LEVEL_W-1:0] lvl;
		logic               found;
		lvl   = LEVEL_W'(LEVELS);
		found = 1'b0;
		for (int l = 0; l < LEVELS; l++) begin
			if (!found && (LEVEL_W'(l) >= start) &&
			    (off + OFF_BITS'(level_width(LEVEL_W'(l))) <= OFF_BITS'(w))) begin
				lvl   = LEVEL_W'(l);
				found = 1'b1;
			end
		end
		return lvl;
	endfunction

	// Apply a restart: latch dimensions, clear counters, pick first panel
	always_comb begin
		clamp_r = clamp_dim(cfg.source_rows);
		clamp_c = clamp_dim(cfg.source_cols);
		if (ctl.restart) begin
			e_cols   = clamp_c;
			e_trans  = cfg.transpose_mode;
			e_h      = cfg.transpose_mode ? clamp_c : clamp_r;
			e_w      = cfg.transpose_mode ? clamp_r : clamp_c;
			e_offset = '0;
			e_row    = '0;
			e_col    = '0;
			e_dest   = '0;
			if (clamp_r == '0 || clamp_c == '0) begin
				e_level = '0;
				e_fin   = 1'b1;
			end else begin
				e_level = settle('0, '0, e_w);
				e_fin   = (e_level >= LEVEL_W'(LEVELS));
			end
		end else begin
			e_cols   = lat_cols_q;
			e_trans  = lat_trans_q;
			e_h      = lat_h_q;
			e_w      = lat_w_q;
			e_offset = offset_q;
			e_row    = row_q;
			e_col    = col_q;
			e_dest   = dest_q;
			e_level  = level_q;
			e_fin    = fin_q || (level_q >= LEVEL_W'(LEVELS));
		end
	end

	// Source address: row * stride + col, operands swapped when transposed
	always_comb begin
		lcol    = e_offset + DIM_BITS'(e_col);
		mul_a   = e_trans ? lcol : e_row;
		mul_c   = e_trans ? e_row : lcol;
		prod    = PROD_W'(mul_a) * PROD_W'(e_cols);
		src_sum = SUM_W'(prod) + SUM_W'(mul_c);
	end

	// Advance column, then row, then panel
	always_comb begin
		cur_size = level_width(e_level);
		off_next = OFF_BITS'(e_offset) + OFF_BITS'(cur_size);
		n_level  = e_level;
		n_offset = e_offset;
		n_row    = e_row;
		n_col    = e_col;
		n_dest   = e_dest;
		n_fin    = e_fin;
		if (!e_fin) begin
			n_dest = e_dest + INDEX_BITS'(1);
			if ((SIZE_W + 1)'(e_col) + (SIZE_W + 1)'(1) >= (SIZE_W + 1)'(cur_size)) begin
				n_col = '0;
				if ((DIM_BITS + 1)'(e_row) + (DIM_BITS + 1)'(1) >= (DIM_BITS + 1)'(e_h)) begin
					n_row    = '0;
					n_offset = DIM_BITS'(off_next);
					n_level  = settle(e_level, off_next, e_w);
					n_fin    = (n_level >= LEVEL_W'(LEVELS));
				end else begin
					n_row = e_row + DIM_BITS'(1);
				end
			end else begin
				n_col = e_col + SIZE_W'(1);
			end
		end
	end

	// Result of this step
	always_comb begin
		if (e_fin) begin
			source_index = '0;
			dest_index   = '0;
			last_element = 1'b0;
			exhausted    = 1'b1;
		end else begin
			source_index = INDEX_BITS'(src_sum);
			dest_index   = e_dest;
			last_element = n_fin;
			exhausted    = 1'b0;
		end
	end

	// State update on each taken step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			offset_q    <= '0;
			row_q       <= '0;
			col_q       <= '0;
			dest_q      <= '0;
			fin_q       <= 1'b1;
			lat_cols_q  <= '0;
			lat_h_q     <= '0;
			lat_w_q     <= '0;
			lat_trans_q <= 1'b0;
		end else if (ctl.step) begin
			level_q     <= n_level;
			offset_q    <= n_offset;
			row_q       <= n_row;
			col_q       <= n_col;
			dest_q      <= n_dest;
			fin_q       <= n_fin;
			lat_cols_q  <= e_cols;
			lat_h_q     <= e_h;
			lat_w_q     <= e_w;
			lat_trans_q <= e_trans;
		end
	end

	`MMBP_ASSERT_NOW(a_col_in_panel, !fin_q, col_q < level_width(level_q),
		"column beyond panel width")
	`MMBP_ASSERT_NEXT(a_last_sets_fin, ctl.step && last_element, fin_q,
		"last element did not end the walk")
	`MMBP_ASSERT_NOW(a_fin_needs_restart, $fell(fin_q), $past(ctl.step && ctl.restart),
		"walk resumed without restart")

endmodule

`default_nettype wire

/* rtl/matmul_b_panel_pack_addr_unit.sv */
// Top level of the panel packing address unit: input register, walk unit
// and result register. Depends on mmbp_pkg, mmbp_cfg_regs and mmbp_walk.
`default_nettype none

// Issues one packed-panel source address per transfer. Each accepted input
// item (restart or next) yields exactly one result, which passes from the input
// register through the walk unit into the result register; a new item is
// taken every cycle while the result side does not stall. The walk unit
// finishes each step (address multiply-add and counter advance) between the
// input register and the result register. The result register holds a
// waiting result while the input register already takes the next item;
// stall on the result side reaches the input side in the same cycle. A
// restart latches the configuration registers.
module matmul_b_panel_pack_addr_unit
	import mmbp_pkg::*;
#(
	parameter int MAX_DIM    = 4096,
	parameter int INDEX_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  restart,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [INDEX_BITS-1:0]      source_index,
	output logic [INDEX_BITS-1:0]      dest_index,
	output logic                       last_element,
	output logic                       exhausted
);

	`include "matmul_b_panel_pack_addr_unit_defines.svh"

	cfg_t                  cfg;
	walk_ctl_t             ctl;
	logic                  valid_s1;
	logic                  restart_s1;
	logic                  fire;
	logic                  in_xfer;
	logic [INDEX_BITS-1:0] w_source_index;
	logic [INDEX_BITS-1:0] w_dest_index;
	logic                  w_last;
	logic                  w_exh;
	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] source_index_q;
	logic [INDEX_BITS-1:0] dest_index_q;
	logic                  last_q;
	logic                  exh_q;

	mmbp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: step when the result register is free or being drained
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign in_xfer  = in_valid && !in_stall;

	assign ctl.step    = fire;
	assign ctl.restart = restart_s1;

	mmbp_walk #(
		.MAX_DIM    (MAX_DIM),
		.INDEX_BITS (INDEX_BITS)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ctl          (ctl),
		.source_index (w_source_index),
		.dest_index   (w_dest_index),
		.last_element (w_last),
		.exhausted    (w_exh)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			restart_s1 <= restart;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			source_index_q <= w_source_index;
			dest_index_q   <= w_dest_index;
			last_q         <= w_last;
			exh_q          <= w_exh;
		end
	end

	assign out_valid    = out_valid_q;
	assign source_index = source_index_q;
	assign dest_index   = dest_index_q;
	assign last_element = last_q;
	assign exhausted    = exh_q;

	`MMBP_ASSERT_NOW(a_exhausted_zero, out_valid_q && exh_q,
		(source_index_q == '0) && (dest_index_q == '0) && !last_q,
		"exhausted result carries data")

endmodule

`default_nettype wire
